// File: sv/srbk_pkg.sv
`default_nettype none
package srbk_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int KEY_W       = 32;
  localparam int ACTION_W    = 2;
  localparam int OCC_W       = 6;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LIST   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_NOTFOUND = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_ENTRY    = 3'd4
  } status_t;

endpackage
`default_nettype wire

// File: sv/srbk_in_if.sv
`default_nettype none
interface srbk_in_if;
  import srbk_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [ACTION_W-1:0]       action;
  logic signed [KEY_W-1:0]   key;

  modport source (output valid, output action, output key, input ready);
  modport sink   (input valid, input action, input key, output ready);
endinterface
`default_nettype wire

// File: sv/srbk_out_if.sv
`default_nettype none
interface srbk_out_if;
  import srbk_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [2:0]                status;
  logic signed [KEY_W-1:0]   entry_key;
  logic [OCC_W-1:0]          occupancy;
  logic                      last;

  modport source (output valid, output status, output entry_key, output occupancy,
                  output last, input ready);
  modport sink   (input valid, input status, input entry_key, input occupancy,
                  input last, output ready);
endinterface
`default_nettype wire

// File: sv/srbk_ram.sv
`default_nettype none
module srbk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/stack_remove_by_key_core.sv
`default_nettype none
// Bounded stack of signed 32-bit keys with push, remove-by-key and list.
// A push returns one result (ok, or full when the stack holds STACK_DEPTH
// entries). A remove scans from the top one entry at a time through a single
// comparator, then closes the gap by moving each entry above the hit down one
// place; a hit on the bottom entry is the slowest case. A remove returns ok
// or not found. A list returns one result per entry, bottom to top, with last
// set on the final one; an empty stack gives a single empty result. The key
// store is one RAM with one registered read port and one write port. Action
// code 3 is taken and dropped with no result. The input is not ready while a
// transaction is in progress; a finished result sits in the output register,
// so the next transaction can be taken while the previous result still waits.
module stack_remove_by_key_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  srbk_in_if.sink    in_chan,
  srbk_out_if.source out_chan
);
  import srbk_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT,
    ST_R_RD,
    ST_R_CMP,
    ST_S_RD,
    ST_S_WR,
    ST_L_RD,
    ST_L_DATA
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;

  // pending result, waiting for the output register
  status_t            res_status_r, res_status_nxt;
  logic [KEY_W-1:0]   res_key_r, res_key_nxt;
  logic               res_last_r, res_last_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [KEY_W-1:0]   out_key_r, out_key_nxt;
  logic [OCC_W-1:0]   out_occ_r, out_occ_nxt;
  logic               out_last_r, out_last_nxt;

  // key store port
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [KEY_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [KEY_W-1:0]   ram_rdata;

  logic               in_take;
  logic               out_free;
  logic [CNT_W-1:0]   idx_ext;
  logic               key_hit;

  srbk_ram #(
    .WIDTH (KEY_W),
    .DEPTH (STACK_DEPTH)
  ) u_key_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_chan.ready      = (state_r == ST_IDLE);
  assign in_take            = in_chan.valid && (state_r == ST_IDLE);
  assign out_free           = !out_valid_r || out_chan.ready;

  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = out_status_r;
  assign out_chan.entry_key = out_key_r;
  assign out_chan.occupancy = out_occ_r;
  assign out_chan.last      = out_last_r;

  assign idx_ext = CNT_W'(idx_r);
  // the one shared comparator: stored key against the requested key
  assign key_hit = (ram_rdata == key_r);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    key_nxt        = key_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_last_nxt   = res_last_r;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_occ_nxt    = out_occ_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = key_r;
    ram_raddr      = idx_r;

    // drain the output register on a taken transaction
    out_valid_nxt  = out_valid_r && !out_chan.ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          key_nxt      = in_chan.key;
          res_key_nxt  = '0;
          res_last_nxt = 1'b1;
          unique case (action_t'(in_chan.action))
            ACT_PUSH: begin
              state_nxt = ST_EMIT;
              if (cnt_r == CNT_W'(STACK_DEPTH)) begin
                res_status_nxt = STAT_FULL;
              end else begin
                // write the new key straight onto the top slot
                ram_we         = 1'b1;
                ram_waddr      = cnt_r[ADDR_W-1:0];
                ram_wdata      = in_chan.key;
                cnt_nxt        = cnt_r + 1'b1;
                res_status_nxt = STAT_OK;
              end
            end
            ACT_REMOVE: begin
              if (cnt_r == '0) begin
                res_status_nxt = STAT_NOTFOUND;
                state_nxt      = ST_EMIT;
              end else begin
                idx_nxt   = ADDR_W'(cnt_r - 1'b1);
                state_nxt = ST_R_RD;
              end
            end
            ACT_LIST: begin
              if (cnt_r == '0) begin
                res_status_nxt = STAT_EMPTY;
                state_nxt      = ST_EMIT;
              end else begin
                idx_nxt   = '0;
                state_nxt = ST_L_RD;
              end
            end
            ACT_NONE: begin
              // drop the transaction, no result
              state_nxt = ST_IDLE;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_key_nxt    = res_key_r;
          out_occ_nxt    = OCC_W'(cnt_r);
          out_last_nxt   = res_last_r;
          if (res_last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            // advance to the next listed entry
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_L_RD;
          end
        end
      end

      ST_R_RD: begin
        ram_raddr = idx_r;
        state_nxt = ST_R_CMP;
      end

      ST_R_CMP: begin
        if (key_hit) begin
          if (idx_ext + 1'b1 == cnt_r) begin
            // hit on the top entry: nothing to move
            cnt_nxt        = cnt_r - 1'b1;
            res_status_nxt = STAT_OK;
            state_nxt      = ST_EMIT;
          end else begin
            state_nxt = ST_S_RD;
          end
        end else if (idx_r == '0) begin
          res_status_nxt = STAT_NOTFOUND;
          state_nxt      = ST_EMIT;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = ST_R_RD;
        end
      end

      ST_S_RD: begin
        ram_raddr = idx_r + 1'b1;
        state_nxt = ST_S_WR;
      end

      ST_S_WR: begin
        // move the entry above down into the gap
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        if (idx_ext + 2'd2 == cnt_r) begin
          cnt_nxt        = cnt_r - 1'b1;
          res_status_nxt = STAT_OK;
          state_nxt      = ST_EMIT;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_S_RD;
        end
      end

      ST_L_RD: begin
        ram_raddr = idx_r;
        state_nxt = ST_L_DATA;
      end

      ST_L_DATA: begin
        res_status_nxt = STAT_ENTRY;
        res_key_nxt    = ram_rdata;
        res_last_nxt   = (idx_ext + 1'b1 == cnt_r);
        state_nxt      = ST_EMIT;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_last_r   <= res_last_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_occ_r    <= out_occ_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import srbk_pkg::*;

  // A driver process feeds push, remove and list transactions from a queue of
  // pending operations; the initial block fills that queue one phase at a time
  // and waits for the block to drain between phases. A monitor process samples
  // both channels at the rising edge. Every accepted input transaction is run
  // through a behavioral stack in this file, and the results it yields are
  // queued. Every result transaction from the block is then checked field by
  // field against the oldest queued result.
  //
  // Phases:
  //   directed   - field extremes, duplicate keys, removes that miss, remove on
  //                an empty stack, list on an empty stack, the unused action code
  //   fill       - a burst of pushes past the depth (push when full), then a
  //                full-depth list, then push-heavy random traffic
  //   mixed      - random traffic, sender idle most cycles
  //   drain      - remove-heavy random traffic, receiver stalling most cycles
  //   both       - random traffic, sender idle and receiver stalling
  //   backpressure - receiver holds off for a long stretch while the sender
  //                keeps offering, so the block fills and stalls its input

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 8;
  localparam int LONG_HOLD = 400;
  // Allows for the slowest remove, plus margin for the output stage.
  localparam int TAIL_CYCLES = 4 * STACK_DEPTH + 40;
  // Slowest legal run: ~370 transactions, each a full-depth list, every
  // result waiting out a heavily stalled receiver; the limit allows for that.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_PRINTS = 30;

  typedef struct {
    action_t                 action;
    logic signed [KEY_W-1:0] key;
  } stack_op_t;

  typedef struct {
    status_t                 status;
    logic signed [KEY_W-1:0] entry_key;
    logic [OCC_W-1:0]        occupancy;
    logic                    last;
  } stack_result_t;

  logic clk = 1'b0;
  logic rst_n;

  srbk_in_if  in_chan ();
  srbk_out_if out_chan ();

  stack_remove_by_key_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Operations waiting for the driver, and results the block still owes.
  stack_op_t     pending_ops[$];
  stack_result_t owed_results[$];

  // Shadow of the block's stack.
  logic signed [KEY_W-1:0] shadow_keys [STACK_DEPTH];
  int                      shadow_fill = 0;

  // Traffic shaping, set by the sequencer between phases.
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic long_hold_req = 1'b0;

  // Owned by the receiver process.
  int   hold_left = 0;
  logic hold_used = 1'b0;

  // Set by the monitor at each rising edge; read by the driver at the next
  // falling edge.
  logic in_taken = 1'b0;

  int cycle_count = 0;
  int err_count = 0;
  int ops_accepted = 0;
  int results_checked = 0;
  int full_seen = 0;
  int miss_seen = 0;
  int empty_seen = 0;
  int ignored_seen = 0;
  int peak_fill = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
  endtask

  function automatic void owe(status_t st, logic signed [KEY_W-1:0] k, logic fin);
    stack_result_t r;
    r.status    = st;
    r.entry_key = k;
    r.occupancy = shadow_fill[OCC_W-1:0];
    r.last      = fin;
    owed_results.push_back(r);
  endfunction

  // Apply one accepted transaction to the shadow stack and queue its results.
  function automatic void stack_apply(action_t act, logic signed [KEY_W-1:0] k);
    int hit;
    hit = -1;
    case (act)
      ACT_PUSH: begin
        if (shadow_fill >= STACK_DEPTH) begin
          full_seen++;
          owe(STAT_FULL, '0, 1'b1);
        end else begin
          shadow_keys[shadow_fill] = k;
          shadow_fill++;
          if (shadow_fill > peak_fill) peak_fill = shadow_fill;
          owe(STAT_OK, '0, 1'b1);
        end
      end
      ACT_REMOVE: begin
        // Scan from the top; the topmost match wins.
        for (int i = shadow_fill - 1; i >= 0 && hit < 0; i--)
          if (shadow_keys[i] == k) hit = i;
        if (hit < 0) begin
          miss_seen++;
          owe(STAT_NOTFOUND, '0, 1'b1);
        end else begin
          for (int j = hit; j + 1 < shadow_fill; j++)
            shadow_keys[j] = shadow_keys[j + 1];
          shadow_fill--;
          owe(STAT_OK, '0, 1'b1);
        end
      end
      ACT_LIST: begin
        if (shadow_fill == 0) begin
          empty_seen++;
          owe(STAT_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_fill; i++)
            owe(STAT_ENTRY, shadow_keys[i], i + 1 == shadow_fill);
        end
      end
      default: ignored_seen++;
    endcase
  endfunction

  // Driver: change inputs at the falling edge; hold an offered transaction
  // until the monitor saw it taken.
  always @(negedge clk) begin : drive_in
    logic      offer;
    stack_op_t op;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_taken) begin
      offer = (pending_ops.size() != 0) && ($urandom_range(99) >= send_idle_pct);
      if (offer) begin
        op = pending_ops.pop_front();
        in_chan.valid  <= 1'b1;
        in_chan.action <= op.action;
        in_chan.key    <= op.key;
      end else begin
        // Idle cycle: scramble the payload so a stray capture shows up.
        in_chan.valid  <= 1'b0;
        in_chan.action <= 2'($urandom_range(3));
        in_chan.key    <= $urandom;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_chan.ready <= 1'b0;
      hold_left      <= hold_left - 1;
    end else if (long_hold_req && !hold_used) begin
      out_chan.ready <= 1'b0;
      hold_left      <= LONG_HOLD - 1;
      hold_used      <= 1'b1;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: sample both channels at the rising edge.
  always @(posedge clk) begin : watch
    stack_result_t want;
    in_taken = rst_n && in_chan.valid && in_chan.ready;
    if (in_taken) begin
      ops_accepted++;
      stack_apply(action_t'(in_chan.action), in_chan.key);
    end
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_checked++;
      if (owed_results.size() == 0) begin
        report("result with none owed, status", 32'(out_chan.status), '0);
      end else begin
        want = owed_results.pop_front();
        if (out_chan.status !== want.status)
          report("status", 32'(out_chan.status), 32'(want.status));
        if (out_chan.entry_key !== want.entry_key)
          report("entry_key", out_chan.entry_key, want.entry_key);
        if (out_chan.occupancy !== want.occupancy)
          report("occupancy", 32'(out_chan.occupancy), 32'(want.occupancy));
        if (out_chan.last !== want.last)
          report("last", 32'(out_chan.last), 32'(want.last));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("stack_remove_by_key_core: mismatch");
      $finish;
    end
  end

  task automatic add_op(input action_t act, input logic signed [KEY_W-1:0] k);
    stack_op_t op;
    op.action = act;
    op.key    = k;
    pending_ops.push_back(op);
  endtask

  // Mostly keys from a small pool so removes hit, sometimes any 32-bit value.
  function automatic logic signed [KEY_W-1:0] pick_key();
    logic signed [KEY_W-1:0] k;
    if ($urandom_range(9) < 6) begin
      case ($urandom_range(7))
        0: k = '0;
        1: k = -1;
        2: k = {1'b1, {(KEY_W-1){1'b0}}};
        3: k = {1'b0, {(KEY_W-1){1'b1}}};
        default: k = KEY_W'($urandom_range(4, 1));
      endcase
    end else begin
      k = $urandom;
    end
    return k;
  endfunction

  task automatic add_random(input int count, input int push_pct, input int remove_pct);
    int r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < push_pct)                   add_op(ACT_PUSH, pick_key());
      else if (r < push_pct + remove_pct) add_op(ACT_REMOVE, pick_key());
      else if (r < 97)                    add_op(ACT_LIST, pick_key());
      else                                add_op(ACT_NONE, pick_key());
    end
  endtask

  // Wait until the driver is empty and every owed result has arrived.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_ops.size() != 0 || in_chan.valid || owed_results.size() != 0);
  endtask

  task automatic set_traffic(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  initial begin
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.action = ACT_NONE;
    in_chan.key    = '0;
    out_chan.ready = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, duplicates, misses, empty cases, unused code.
    set_traffic(0, 0);
    add_op(ACT_LIST, 32'h1234_5678);
    add_op(ACT_REMOVE, 5);
    add_op(ACT_PUSH, KEY_MIN);
    add_op(ACT_PUSH, KEY_MAX);
    add_op(ACT_PUSH, 0);
    add_op(ACT_PUSH, -1);
    add_op(ACT_PUSH, KEY_MAX);
    add_op(ACT_LIST, 0);
    add_op(ACT_REMOVE, KEY_MAX);
    add_op(ACT_LIST, -1);
    add_op(ACT_REMOVE, 99);
    add_op(ACT_NONE, -1);
    add_op(ACT_REMOVE, KEY_MIN);
    add_op(ACT_LIST, KEY_MAX);
    add_op(ACT_REMOVE, -1);
    add_op(ACT_REMOVE, 0);
    add_op(ACT_REMOVE, KEY_MAX);
    add_op(ACT_LIST, 0);
    add_op(ACT_NONE, 0);
    wait_drained();

    // Fill past the depth, list the full stack, then push-heavy traffic.
    repeat (STACK_DEPTH + 2) add_op(ACT_PUSH, pick_key());
    add_op(ACT_LIST, 0);
    add_op(ACT_REMOVE, KEY_MAX);
    add_random(40, 70, 15);
    wait_drained();

    set_traffic(86, 0);
    add_random(90, 45, 35);
    wait_drained();

    set_traffic(0, 86);
    add_random(90, 25, 60);
    wait_drained();

    set_traffic(26, 26);
    add_random(70, 45, 35);
    wait_drained();

    // Backpressure: receiver holds off while list-heavy traffic keeps coming.
    set_traffic(0, 0);
    long_hold_req = 1'b1;
    repeat (6) add_op(ACT_PUSH, pick_key());
    add_random(25, 40, 10);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (owed_results.size() != 0)
      report("results never delivered", 0, owed_results.size());

    $display("%0d transactions in (%0d ignored), %0d results checked, peak depth %0d",
             ops_accepted, ignored_seen, results_checked, peak_fill);
    $display("full pushes %0d, missed removes %0d, empty lists %0d, errors %0d",
             full_seen, miss_seen, empty_seen, err_count);
    if (err_count == 0)
      $display("stack_remove_by_key_core: match");
    else
      $display("stack_remove_by_key_core: mismatch");
    $finish;
  end

endmodule
